### src/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is held.
`define DFR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("deframer assertion failed");

// Clocked assertion that also holds during reset.
`define DFR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("deframer assertion failed");

`endif

### src/dfr_pkg.sv
`default_nettype none

package dfr_pkg;

    // Frame buffer geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Config register geometry
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CMP_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 1'd1;

    // Register reset values
    localparam logic [CFG_W-1:0] MIN_LEN_RST = 5'd3;
    localparam logic [CFG_W-1:0] MAX_LEN_RST = 5'd16;

    // Input commands
    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Byte constants
    localparam logic [7:0] TERM_BYTE = 8'hFF;
    localparam logic [7:0] LEAD_MASK = 8'h80;

    // Controls from the sequencer to the cell row
    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] load_idx;
        logic             shift;
    } t_chain_ctl;

endpackage

`default_nettype wire

### src/dfr_in_if.sv
`default_nettype none

interface dfr_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

`default_nettype wire

### src/dfr_out_if.sv
`default_nettype none

interface dfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

`default_nettype wire

### src/dfr_cell.sv
`default_nettype none

module dfr_cell (
    input  wire logic                    i_clk,
    input  wire logic [dfr_pkg::IDX_W-1:0] i_idx,
    input  wire dfr_pkg::t_chain_ctl     i_ctl,
    input  wire logic [7:0]              i_data,
    input  wire logic [7:0]              i_next,
    output logic [7:0]                   o_byte
);

    logic [7:0] r_byte;

    // Take the neighbor's byte on a shift, else capture when addressed
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte <= i_next;
        end else if (i_ctl.load && (i_ctl.load_idx == i_idx)) begin
            r_byte <= i_data;
        end
    end

    assign o_byte = r_byte;

endmodule

`default_nettype wire

### src/dfr_ctrl.sv
`default_nettype none

module dfr_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_command,
    input  wire logic [7:0]                  i_in_data,
    output logic                             o_in_ready,
    output logic                             o_out_valid,
    output logic                             o_out_last,
    input  wire logic                        i_out_ready,
    input  wire logic                        i_lead,
    input  wire logic                        i_cfg_we,
    input  wire logic [dfr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [dfr_pkg::CFG_W-1:0]   i_cfg_data,
    output dfr_pkg::t_chain_ctl              o_ctl
);

    logic [dfr_pkg::CNT_W-1:0] r_count, n_count;
    logic [dfr_pkg::CNT_W-1:0] r_left, n_left;
    logic [dfr_pkg::CFG_W-1:0] r_min, r_max;

    logic                      w_acc;
    logic                      w_take;
    logic                      w_room;
    logic                      w_lead;
    logic                      w_ok;
    logic [dfr_pkg::CNT_W-1:0] w_len;
    logic [dfr_pkg::CMP_W-1:0] w_len_c;

    // Handshake: input only while no frame streams out
    assign o_in_ready  = (r_left == '0);
    assign o_out_valid = (r_left != '0);
    assign o_out_last  = (r_left == dfr_pkg::CNT_W'(1));
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_take      = o_out_valid && i_out_ready;

    // Frame check on a terminator
    assign w_room  = (r_count < dfr_pkg::CNT_W'(dfr_pkg::DEPTH));
    assign w_len   = r_count + dfr_pkg::CNT_W'(1);
    assign w_len_c = dfr_pkg::CMP_W'(w_len);
    assign w_lead  = (r_count == '0) ? ((i_in_data & dfr_pkg::LEAD_MASK) != '0) : i_lead;
    assign w_ok    = w_room && w_lead
                     && (w_len_c >= dfr_pkg::CMP_W'(r_min))
                     && (w_len_c <= dfr_pkg::CMP_W'(r_max));

    // Drive the cell row
    assign o_ctl.load     = w_acc && (i_in_command == dfr_pkg::CMD_BYTE) && w_room;
    assign o_ctl.load_idx = r_count[dfr_pkg::IDX_W-1:0];
    assign o_ctl.shift    = w_take;

    // Advance count and beats left
    always_comb begin
        n_count = r_count;
        n_left  = r_left;
        priority if (w_acc) begin
            if (i_in_command == dfr_pkg::CMD_CLEAR) begin
                n_count = '0;
            end else if (i_in_data == dfr_pkg::TERM_BYTE) begin
                n_count = '0;
                if (w_ok) begin
                    n_left = w_len;
                end
            end else if (w_room) begin
                n_count = w_len;
            end
        end else if (w_take) begin
            n_left = r_left - dfr_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_left  <= '0;
        end else begin
            r_count <= n_count;
            r_left  <= n_left;
        end
    end

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= dfr_pkg::MIN_LEN_RST;
            r_max <= dfr_pkg::MAX_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dfr_pkg::CFG_MIN_LEN: r_min <= i_cfg_data;
                dfr_pkg::CFG_MAX_LEN: r_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

### src/terminated_frame_deframer.sv
`default_nettype none

// Terminated frame deframer. Each input beat is either a received byte
// (command 0) or a clear (command 1). Bytes are kept in a row of 16 byte
// cells at the position given by the count since the last 0xFF or clear;
// on 0xFF the frame length, terminator included, is checked against
// min_frame_len and max_frame_len (config index 0 and 1, reset 3 and 16)
// and the first byte must have bit 7 set. A good frame of L bytes streams
// out of cell 0, the row shifting one cell toward the output per beat,
// with frame_last on the terminator. A terminator that releases a frame
// of L bytes holds the input off for the L output beats. Overlong runs
// are dropped.
module terminated_frame_deframer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    dfr_in_if.sink                             i_in,
    dfr_out_if.source                          o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [dfr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [dfr_pkg::CFG_W-1:0]     i_cfg_data
);

    dfr_pkg::t_chain_ctl w_ctl;
    logic [7:0]          w_byte [0:dfr_pkg::DEPTH];

    // Sequencer: counts, checks and paces the output
    dfr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_command (i_in.command),
        .i_in_data    (i_in.data_byte),
        .o_in_ready   (i_in.ready),
        .o_out_valid  (o_out.valid),
        .o_out_last   (o_out.frame_last),
        .i_out_ready  (o_out.ready),
        .i_lead       (w_byte[0][7]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_ctl        (w_ctl)
    );

    // Row of byte cells, cell 0 faces the output
    assign w_byte[dfr_pkg::DEPTH] = '0;

    for (genvar g = 0; g < dfr_pkg::DEPTH; g++) begin : g_cell
        dfr_cell u_cell (
            .i_clk  (i_clk),
            .i_idx  (dfr_pkg::IDX_W'(g)),
            .i_ctl  (w_ctl),
            .i_data (i_in.data_byte),
            .i_next (w_byte[g+1]),
            .o_byte (w_byte[g])
        );
    end

    assign o_out.frame_byte = w_byte[0];

endmodule

`default_nettype wire

### src/dfr_checker.sv
`default_nettype none

`include "assert_macros.svh"

module dfr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_in_command,
    input wire logic [7:0] i_in_data_byte,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_frame_byte,
    input wire logic       i_out_frame_last
);

    logic       w_in_acc;
    logic       w_in_plain;
    logic       w_out_acc;
    logic       w_out_wait;
    logic [8:0] w_out_beat;

    assign w_in_acc   = i_in_valid && i_in_ready;
    assign w_in_plain = w_in_acc && ((i_in_command == dfr_pkg::CMD_CLEAR)
                        || (i_in_data_byte != dfr_pkg::TERM_BYTE));
    assign w_out_acc  = i_out_valid && i_out_ready;
    assign w_out_wait = i_out_valid && !i_out_ready;
    assign w_out_beat = {i_out_frame_byte, i_out_frame_last};

    // Input is open exactly when no frame is streaming
    `DFR_ASSERT(a_ready_xor_valid, i_clk, i_rst_n, i_in_ready != i_out_valid)

    // A byte or clear that is not a terminator never starts a frame
    `DFR_ASSERT(a_no_frame_without_term, i_clk, i_rst_n, w_in_plain |=> !i_out_valid)

    // A frame continues until its last beat, then stops
    `DFR_ASSERT(a_frame_continues, i_clk, i_rst_n, (w_out_acc && !i_out_frame_last) |=> i_out_valid)
    `DFR_ASSERT(a_frame_ends, i_clk, i_rst_n, (w_out_acc && i_out_frame_last) |=> !i_out_valid)

    // A stalled output beat holds
    `DFR_ASSERT(a_out_hold, i_clk, i_rst_n, w_out_wait |=> (i_out_valid && $stable(w_out_beat)))

endmodule

bind terminated_frame_deframer dfr_checker u_dfr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_command     (i_in.command),
    .i_in_data_byte   (i_in.data_byte),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_frame_byte (o_out.frame_byte),
    .i_out_frame_last (o_out.frame_last)
);

`default_nettype wire
